// ===== hw/rtl/usr_pkg.sv =====
// shared types and constants for the stalled-link recovery supervisor
package usr_pkg;

   localparam int CfgWidth = 24;
   localparam int CsrIndexWidth = 3;
   localparam int NowWidth = 32;
   localparam int ReqDataWidth = 40;
   localparam int RspDataWidth = 8;

   // register indexes on the csr channel
   localparam logic [CsrIndexWidth-1:0] CSR_ACTIVITY_WINDOW = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_WAKEUP_RETRY = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_RESTART_AFTER = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_RESTART_RETRY = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_STUCK_RESET = 3'd4;

   localparam logic [CfgWidth-1:0] ACTIVITY_WINDOW_RESET = 24'd3000;
   localparam logic [CfgWidth-1:0] WAKEUP_RETRY_RESET = 24'd250;
   localparam logic [CfgWidth-1:0] RESTART_AFTER_RESET = 24'd2000;
   localparam logic [CfgWidth-1:0] RESTART_RETRY_RESET = 24'd3000;
   localparam logic [CfgWidth-1:0] STUCK_RESET_RESET = 24'd10000;

   // request kinds carried in tuser
   localparam logic KIND_POLL = 1'b0;
   localparam logic KIND_KEY = 1'b1;

   typedef struct packed {
      logic [CfgWidth-1:0] activity_window_ms;
      logic [CfgWidth-1:0] wakeup_retry_ms;
      logic [CfgWidth-1:0] restart_after_ms;
      logic [CfgWidth-1:0] restart_retry_ms;
      logic [CfgWidth-1:0] stuck_reset_ms;
   } cfg_type;

endpackage

// ===== hw/rtl/usr_csr.sv =====
// configuration register file for the recovery supervisor
module usr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [usr_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [usr_pkg::CfgWidth-1:0]      csr_data,
   output usr_pkg::cfg_type                  cfg
);
   import usr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ACTIVITY_WINDOW: cfg_in.activity_window_ms = csr_data;
            CSR_WAKEUP_RETRY: cfg_in.wakeup_retry_ms = csr_data;
            CSR_RESTART_AFTER: cfg_in.restart_after_ms = csr_data;
            CSR_RESTART_RETRY: cfg_in.restart_retry_ms = csr_data;
            CSR_STUCK_RESET: cfg_in.stuck_reset_ms = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.activity_window_ms <= ACTIVITY_WINDOW_RESET;
         cfg_ff.wakeup_retry_ms <= WAKEUP_RETRY_RESET;
         cfg_ff.restart_after_ms <= RESTART_AFTER_RESET;
         cfg_ff.restart_retry_ms <= RESTART_RETRY_RESET;
         cfg_ff.stuck_reset_ms <= STUCK_RESET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/usb_stall_escalating_recovery.sv =====
// Stalled USB link recovery supervisor: key press tracking and escalating requests.
//
// Requests arrive on the req_ stream: tuser carries the kind (poll or key event),
// tdata the timestamp and link status flags. Every request yields exactly one
// response on the rsp_ stream, whose tdata holds the wake, restart and reset pulses.
// A poll from the link-owning side while the link is stalled runs the stall clock
// and, inside the key-activity window, issues rate-limited wake and restart
// requests, or a reset once the link has been up and the stall has gone on long.
// A request passes through an input register, then the decision logic (a handful
// of wrapping subtractions and compares) into the response register. One request
// is taken every cycle while rsp_tready stays high; the state update happens
// as a request moves into the response register, so the next request sees it.
// When the receiver holds rsp_tready low the response register holds, the input
// register fills, and req_tready drops until the response is taken.
// The csr_ channel writes the five timing registers; it is always ready and
// should be used only while no request is in flight.
// Synchronous reset clears all timestamps, the has-been-active flag and both
// pipeline valids, and restores the register defaults.
module usb_stall_escalating_recovery #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // now_ms[31:0], key_pressed[32], usb_active[33], remote_wakeup_enabled[34],
   // is_master[35], zero fill [39:36]
   input  logic [usr_pkg::ReqDataWidth-1:0]  req_tdata,
   // kind[0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // wake_request[0], restart_request[1], reset_request[2], zero fill [7:3]
   output logic [usr_pkg::RspDataWidth-1:0]  rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [usr_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [usr_pkg::CfgWidth-1:0]      csr_data
);
   import usr_pkg::*;

   localparam int CmpWidth = (TIME_WIDTH > CfgWidth) ? TIME_WIDTH : CfgWidth;
   localparam logic [TIME_WIDTH-1:0] TimeZero = '0;
   localparam logic [TIME_WIDTH-1:0] TimeOne = TIME_WIDTH'(1);

   cfg_type cfg;

   usr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // input register
   logic                    in_valid_ff;
   logic                    in_kind_ff;
   logic [NowWidth-1:0]     in_now_ff;
   logic                    in_pressed_ff;
   logic                    in_active_ff;
   logic                    in_rw_ok_ff;
   logic                    in_master_ff;

   // response register
   logic                    rsp_valid_ff;
   logic                    wake_ff;
   logic                    restart_ff;
   logic                    rst_ff;
   logic                    wake_in;
   logic                    restart_in;
   logic                    rst_in;

   // supervisor state
   logic [TIME_WIDTH-1:0]   last_key_ff;
   logic [TIME_WIDTH-1:0]   stall_start_ff;
   logic [TIME_WIDTH-1:0]   last_wake_ff;
   logic [TIME_WIDTH-1:0]   last_restart_ff;
   logic                    active_seen_ff;
   logic [TIME_WIDTH-1:0]   last_key_in;
   logic [TIME_WIDTH-1:0]   stall_start_in;
   logic [TIME_WIDTH-1:0]   last_wake_in;
   logic [TIME_WIDTH-1:0]   last_restart_in;
   logic                    active_seen_in;

   logic                    advance;
   logic [63:0]             now_wide;
   logic [TIME_WIDTH-1:0]   now;
   logic [TIME_WIDTH-1:0]   stall_eff;
   logic [TIME_WIDTH-1:0]   since_key;
   logic [TIME_WIDTH-1:0]   stall_age;
   logic [TIME_WIDTH-1:0]   since_wake;
   logic [TIME_WIDTH-1:0]   since_restart;
   logic                    in_window;
   logic                    wake_slot;
   logic                    restart_slot;
   logic                    reset_due;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RspDataWidth - 3){1'b0}}, rst_ff, restart_ff, wake_ff};

   assign now_wide = 64'(in_now_ff);
   assign now = now_wide[TIME_WIDTH-1:0];

   // a fresh stall never stores zero, which means not stalled
   assign stall_eff = (stall_start_ff != TimeZero) ? stall_start_ff
                    : ((now != TimeZero) ? now : TimeOne);

   assign since_key = now - last_key_ff;
   assign stall_age = now - stall_eff;
   assign since_wake = now - last_wake_ff;
   assign since_restart = now - last_restart_ff;

   assign in_window = (last_key_ff != TimeZero) &&
                      !(CmpWidth'(since_key) > CmpWidth'(cfg.activity_window_ms));
   assign wake_slot = CmpWidth'(since_wake) > CmpWidth'(cfg.wakeup_retry_ms);
   assign restart_slot = (CmpWidth'(stall_age) > CmpWidth'(cfg.restart_after_ms)) &&
                         (CmpWidth'(since_restart) > CmpWidth'(cfg.restart_retry_ms));
   assign reset_due = active_seen_ff &&
                      (CmpWidth'(stall_age) > CmpWidth'(cfg.stuck_reset_ms));

   always_comb begin
      last_key_in = last_key_ff;
      stall_start_in = stall_start_ff;
      last_wake_in = last_wake_ff;
      last_restart_in = last_restart_ff;
      active_seen_in = active_seen_ff;
      wake_in = 1'b0;
      restart_in = 1'b0;
      rst_in = 1'b0;
      if (in_kind_ff == KIND_KEY) begin
         if (in_pressed_ff) begin
            last_key_in = now;
         end
      end else if (in_master_ff) begin
         if (in_active_ff) begin
            active_seen_in = 1'b1;
            stall_start_in = TimeZero;
         end else begin
            stall_start_in = stall_eff;
            if (in_window) begin
               if (wake_slot) begin
                  last_wake_in = now;
                  wake_in = in_rw_ok_ff;
               end
               // a restart ends the step, so no reset alongside it
               if (restart_slot) begin
                  last_restart_in = now;
                  restart_in = 1'b1;
               end else if (reset_due) begin
                  rst_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff <= req_tuser;
         in_now_ff <= req_tdata[NowWidth-1:0];
         in_pressed_ff <= req_tdata[NowWidth];
         in_active_ff <= req_tdata[NowWidth+1];
         in_rw_ok_ff <= req_tdata[NowWidth+2];
         in_master_ff <= req_tdata[NowWidth+3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wake_ff <= wake_in;
         restart_ff <= restart_in;
         rst_ff <= rst_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_key_ff <= TimeZero;
         stall_start_ff <= TimeZero;
         last_wake_ff <= TimeZero;
         last_restart_ff <= TimeZero;
         active_seen_ff <= 1'b0;
      end else if (advance) begin
         last_key_ff <= last_key_in;
         stall_start_ff <= stall_start_in;
         last_wake_ff <= last_wake_in;
         last_restart_ff <= last_restart_in;
         active_seen_ff <= active_seen_in;
      end
   end

endmodule
